// File: src/round_robin_quantum_scheduler_unit_assert.svh
// Assertion macros for the round-robin quantum scheduler.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RRQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RRQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/rrqs_pkg.sv
// Shared constants, types and helpers of the round-robin quantum scheduler.
// No dependencies; used by the ready queue and the top level.
package rrqs_pkg;

   localparam int MAX_JOBS = 8;
   localparam int NUM_IDS  = 8;
   localparam int ID_W     = 3;
   localparam int VOL_W    = 16;
   localparam int QNT_W    = 8;
   localparam int PTR_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam logic [1:0] ARR_ACCEPTED = 2'd0;
   localparam logic [1:0] ARR_IGNORED  = 2'd1;
   localparam logic [1:0] ARR_DROPPED  = 2'd2;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef struct packed {
      logic            rd;       // read the entry at the head
      logic            pop;      // advance the head
      logic            push;     // write push_id at the tail and advance it
      logic [ID_W-1:0] push_id;
   } queue_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             empty;
      logic             full;
   } queue_stat_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      nxt = (ptr == PTR_W'(MAX_JOBS - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

endpackage

// File: src/rrqs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rrqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rrqs_ready_queue.sv
// Ring-shaped ready queue of job ids: head, tail and fill count around one RAM.
// Depends on rrqs_pkg and rrqs_ram.
module rrqs_ready_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  rrqs_pkg::queue_cmd_type     cmd,
   output logic [rrqs_pkg::ID_W-1:0]   head_id,
   output rrqs_pkg::queue_stat_type    stat
);
   import rrqs_pkg::*;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   rrqs_ram #(
      .WIDTH(ID_W),
      .DEPTH(MAX_JOBS)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (cmd.push),
      .wr_addr(tail_ff),
      .wr_data(cmd.push_id),
      .rd_en  (cmd.rd),
      .rd_addr(head_ff),
      .rd_data(head_id)
   );

   always_comb begin
      head_in  = cmd.pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = cmd.push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      case ({cmd.push, cmd.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(MAX_JOBS));

endmodule

// File: src/round_robin_quantum_scheduler_unit.sv
// Round-robin scheduler with a time quantum.
// Input channel req_*: tuser is the item kind (arrival or tick), tdata carries
// job_id and volume. Every accepted item gives exactly one transaction on rsp_*.
// An arrival stores the job's volume and queues its id; a zero volume is ignored
// and an arrival into a full queue is dropped, both flagged in arrival_status.
// A tick requeues a preempted job behind a non-empty queue, dispatches the head
// of the queue if no job runs or one was preempted, and serves one work unit
// of the running job. csr_wr_en/csr_wr_data write the quantum (reset 4, 0 acts
// as 1); a new value applies from the next quantum load. Write it only while
// the block is idle. Timing: a sequencer takes one item at a time. An arrival
// or idle tick passes through the states DECIDE and OUT, a tick that serves
// the running job through DECIDE, WORK and OUT, and a tick that dispatches
// from the queue through DECIDE, POP, WORK and OUT; the next item is taken in
// the same cycle as the last result appears. The queue RAM and the work RAM
// both have a registered read; a dispatching tick reads them one after the other.
// Reset (synchronous) empties the queue and stops the running job; the RAMs are
// not cleared. While rsp_tready is low the result register holds its
// transaction; the block still takes and works one more item and waits with
// its result.
`include "round_robin_quantum_scheduler_unit_assert.svh"

module round_robin_quantum_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] job_id, [18:3] volume, [23:19] zero
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] served_job, [3] served_valid,
                                    // [4] job_done, [6:5] arrival_status, [7] zero
   output logic        rsp_tuser,   // [0] result_kind
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // quantum
);
   import rrqs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;
   localparam logic [2:0] S_WORK   = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic             kind_ff, kind_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [VOL_W-1:0] vol_ff, vol_in;
   logic [QNT_W-1:0] quantum_ff;
   logic [ID_W-1:0]  running_job_ff, running_job_in;
   logic             running_valid_ff, running_valid_in;
   logic [QNT_W-1:0] quantum_left_ff, quantum_left_in;
   logic             requeue_ff, requeue_in;
   logic [ID_W-1:0]  res_served_ff, res_served_in;
   logic             res_valid_ff, res_valid_in;
   logic             res_done_ff, res_done_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic [QNT_W-1:0] quantum_load;
   logic [VOL_W-1:0] work_next;
   logic [QNT_W-1:0] quantum_dec;

   queue_cmd_type    q_cmd;
   queue_stat_type   q_stat;
   logic [ID_W-1:0]  q_head_id;

   logic             w_wr_en;
   logic [ID_W-1:0]  w_wr_addr;
   logic [VOL_W-1:0] w_wr_data;
   logic             w_rd_en;
   logic [ID_W-1:0]  w_rd_addr;
   logic [VOL_W-1:0] w_rd_data;

   rrqs_ready_queue u_ready_queue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (q_cmd),
      .head_id(q_head_id),
      .stat   (q_stat)
   );

   rrqs_ram #(
      .WIDTH(VOL_W),
      .DEPTH(NUM_IDS)
   ) u_work_ram (
      .clock  (clock),
      .wr_en  (w_wr_en),
      .wr_addr(w_wr_addr),
      .wr_data(w_wr_data),
      .rd_en  (w_rd_en),
      .rd_addr(w_rd_addr),
      .rd_data(w_rd_data)
   );

   assign req_tready   = (state_ff == S_IDLE);
   assign quantum_load = (quantum_ff == '0) ? QNT_W'(1) : quantum_ff;
   assign work_next    = (w_rd_data != '0) ? w_rd_data - 1'b1 : '0;
   assign quantum_dec  = (quantum_left_ff != '0) ? quantum_left_ff - 1'b1 : '0;

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      id_in            = id_ff;
      vol_in           = vol_ff;
      running_job_in   = running_job_ff;
      running_valid_in = running_valid_ff;
      quantum_left_in  = quantum_left_ff;
      requeue_in       = requeue_ff;
      res_served_in    = res_served_ff;
      res_valid_in     = res_valid_ff;
      res_done_in      = res_done_ff;
      res_status_in    = res_status_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_data_in      = rsp_data_ff;
      // drop the result once the receiver takes it
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      q_cmd            = '0;
      w_wr_en          = 1'b0;
      w_wr_addr        = running_job_ff;
      w_wr_data        = work_next;
      w_rd_en          = 1'b0;
      w_rd_addr        = running_job_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               vol_in   = req_tdata[ID_W+VOL_W-1:ID_W];
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_served_in = '0;
            res_valid_in  = 1'b0;
            res_done_in   = 1'b0;
            res_status_in = ARR_ACCEPTED;
            if (kind_ff == KIND_ARRIVAL) begin
               if (vol_ff == '0) begin
                  res_status_in = ARR_IGNORED;
               end else if (q_stat.full) begin
                  res_status_in = ARR_DROPPED;
               end else begin
                  w_wr_en       = 1'b1;
                  w_wr_addr     = id_ff;
                  w_wr_data     = vol_ff;
                  q_cmd.push    = 1'b1;
                  q_cmd.push_id = id_ff;
               end
               state_in = S_OUT;
            end else begin
               requeue_in = 1'b0;
               if (!q_stat.empty && (requeue_ff || !running_valid_ff)) begin
                  // fetch the next job from the head
                  q_cmd.rd = 1'b1;
                  state_in = S_POP;
               end else if (running_valid_ff) begin
                  // preempted job alone in the system runs on with a fresh quantum
                  if (requeue_ff) begin
                     quantum_left_in = quantum_load;
                  end
                  w_rd_en  = 1'b1;
                  state_in = S_WORK;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_POP: begin
            q_cmd.pop = 1'b1;
            // a job still running here was preempted: put it behind the queue
            if (running_valid_ff) begin
               q_cmd.push    = 1'b1;
               q_cmd.push_id = running_job_ff;
            end
            running_job_in   = q_head_id;
            running_valid_in = 1'b1;
            quantum_left_in  = quantum_load;
            w_rd_en          = 1'b1;
            w_rd_addr        = q_head_id;
            state_in         = S_WORK;
         end
         S_WORK: begin
            w_wr_en       = 1'b1;
            res_served_in = running_job_ff;
            res_valid_in  = 1'b1;
            if (work_next == '0) begin
               res_done_in      = 1'b1;
               running_valid_in = 1'b0;
            end else begin
               quantum_left_in = quantum_dec;
               if (quantum_dec == '0) begin
                  requeue_in = 1'b1;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_data_in   = {1'b0, res_status_ff, res_done_ff, res_valid_ff,
                                res_served_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         quantum_ff       <= QNT_W'(4);
         running_job_ff   <= '0;
         running_valid_ff <= 1'b0;
         quantum_left_ff  <= '0;
         requeue_ff       <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         running_job_ff   <= running_job_in;
         running_valid_ff <= running_valid_in;
         quantum_left_ff  <= quantum_left_in;
         requeue_ff       <= requeue_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      vol_ff        <= vol_in;
      res_served_ff <= res_served_in;
      res_valid_ff  <= res_valid_in;
      res_done_ff   <= res_done_in;
      res_status_ff <= res_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   `RRQS_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, q_stat.count <= CNT_W'(MAX_JOBS), "ready queue count beyond depth")
   `RRQS_ASSERT_IMPL(a_no_push_full, clock, reset, q_cmd.push && !q_cmd.pop, !q_stat.full, "push into a full ready queue")
   `RRQS_ASSERT_NEXT(a_pop_dispatch, clock, reset, q_cmd.pop, running_valid_ff && state_ff == S_WORK, "pop without dispatch")
   `RRQS_ASSERT_IMPL(a_done_served, clock, reset, rsp_tvalid_ff && rsp_data_ff[4], rsp_data_ff[3] && rsp_kind_ff == KIND_TICK, "job done without a served tick")

endmodule
